FILE: design/countdown_stopwatch_alarm_timer_unit_defines.svh
// Assertion macros shared by the countdown, stopwatch and alarm timer modules.
`ifndef COUNTDOWN_STOPWATCH_ALARM_TIMER_UNIT_DEFINES_SVH
`define COUNTDOWN_STOPWATCH_ALARM_TIMER_UNIT_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define CDSAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define CDSAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cdsat_pkg.sv
// Package with the types and constants of the countdown, stopwatch and alarm timer.
`default_nettype none

package cdsat_pkg;

  // Field widths of the channels, the configuration port and internal counters.
  localparam int OP_W      = 3;
  localparam int SET_H_W   = 4;
  localparam int SET_MS_W  = 7;
  localparam int HRS_W     = 4;
  localparam int MINSEC_W  = 6;
  localparam int MSEC_W    = 10;
  localparam int EV_W      = 8;
  localparam int HOLD_W    = 16;
  localparam int AGE_W     = 17;
  localparam int MINUTE_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLD   = 1'b1;

  // Counter limits.
  localparam logic [MSEC_W-1:0]   MS_LAST       = 10'd999;
  localparam logic [MINSEC_W-1:0] SM_LAST       = 6'd59;
  localparam logic [HRS_W-1:0]    SW_HOUR_LAST  = 4'd11;
  localparam logic [SET_H_W-1:0]  TMR_HOUR_MAX  = 4'd12;
  localparam logic [SET_MS_W-1:0] SET_FIELD_MAX = 7'd59;
  localparam logic [MINUTE_W-1:0] NO_MINUTE     = 7'd127;
  localparam logic [AGE_W-1:0]    AGE_MAX       = 17'h1FFFF;
  localparam logic [HOLD_W-1:0]   HOLD_RESET    = 16'd10000;

  // Bit positions in the event mask.
  localparam int EV_TMR_START = 0;
  localparam int EV_TMR_STOP  = 1;
  localparam int EV_TMR_FIN   = 2;
  localparam int EV_SW_START  = 3;
  localparam int EV_SW_PAUSE  = 4;
  localparam int EV_SW_RESET  = 5;
  localparam int EV_SW_MINUTE = 6;
  localparam int EV_ALARM     = 7;

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_TMR_START   = 3'd1,
    OP_TMR_STOP    = 3'd2,
    OP_SW_START    = 3'd3,
    OP_SW_PAUSE    = 3'd4,
    OP_SW_RESET    = 3'd5,
    OP_ALARM_START = 3'd6,
    OP_NOP         = 3'd7
  } op_t;

  // One item as handed to the units, with the strobe that applies it.
  typedef struct packed {
    logic                fire;
    op_t                 op;
    logic [SET_H_W-1:0]  set_hours;
    logic [SET_MS_W-1:0] set_minutes;
    logic [SET_MS_W-1:0] set_seconds;
  } cmd_t;

  typedef struct packed {
    logic                running;
    logic [HRS_W-1:0]    hours;
    logic [MINSEC_W-1:0] minutes;
    logic [MINSEC_W-1:0] seconds;
    logic                ev_started;
    logic                ev_stopped;
    logic                ev_finished;
  } tmr_stat_t;

  typedef struct packed {
    logic                running;
    logic [HRS_W-1:0]    hours;
    logic [MINSEC_W-1:0] minutes;
    logic [MINSEC_W-1:0] seconds;
    logic                ev_started;
    logic                ev_paused;
    logic                ev_reset;
    logic                ev_minute;
  } sw_stat_t;

  typedef struct packed {
    logic showing;
    logic ev_alarm;
  } alm_stat_t;

  // Contents of the result register.
  typedef struct packed {
    logic [EV_W-1:0]     event_mask;
    logic                timer_running;
    logic [HRS_W-1:0]    timer_hours;
    logic [MINSEC_W-1:0] timer_minutes;
    logic [MINSEC_W-1:0] timer_seconds;
    logic                stopwatch_running;
    logic [HRS_W-1:0]    stopwatch_hours;
    logic [MINSEC_W-1:0] stopwatch_minutes;
    logic [MINSEC_W-1:0] stopwatch_seconds;
    logic                alarm_showing;
  } res_t;

endpackage

`default_nettype wire

FILE: design/cdsat_if.sv
// Channel interfaces for the input items and the result items.
`default_nettype none

interface cdsat_in_if;
  import cdsat_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SET_H_W-1:0]  set_hours;
  logic [SET_MS_W-1:0] set_minutes;
  logic [SET_MS_W-1:0] set_seconds;

  modport source (output valid, output operation, output set_hours,
                  output set_minutes, output set_seconds, input ready);
  modport sink (input valid, input operation, input set_hours,
                input set_minutes, input set_seconds, output ready);
endinterface

interface cdsat_out_if;
  import cdsat_pkg::*;

  logic                valid;
  logic                ready;
  logic [EV_W-1:0]     event_mask;
  logic                timer_running;
  logic [HRS_W-1:0]    timer_hours;
  logic [MINSEC_W-1:0] timer_minutes;
  logic [MINSEC_W-1:0] timer_seconds;
  logic                stopwatch_running;
  logic [HRS_W-1:0]    stopwatch_hours;
  logic [MINSEC_W-1:0] stopwatch_minutes;
  logic [MINSEC_W-1:0] stopwatch_seconds;
  logic                alarm_showing;

  modport source (output valid, output event_mask, output timer_running,
                  output timer_hours, output timer_minutes, output timer_seconds,
                  output stopwatch_running, output stopwatch_hours,
                  output stopwatch_minutes, output stopwatch_seconds,
                  output alarm_showing, input ready);
  modport sink (input valid, input event_mask, input timer_running,
                input timer_hours, input timer_minutes, input timer_seconds,
                input stopwatch_running, input stopwatch_hours,
                input stopwatch_minutes, input stopwatch_seconds,
                input alarm_showing, output ready);
endinterface

`default_nettype wire

FILE: design/cdsat_countdown.sv
// Countdown timer kept as hours, minutes, seconds and milliseconds counters.
`default_nettype none
`include "countdown_stopwatch_alarm_timer_unit_defines.svh"

module cdsat_countdown (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdsat_pkg::cmd_t       cmd,
  output cdsat_pkg::tmr_stat_t  stat
);
  import cdsat_pkg::*;

  logic [HRS_W-1:0]    tmr_h_r,  tmr_h_nxt;
  logic [MINSEC_W-1:0] tmr_m_r,  tmr_m_nxt;
  logic [MINSEC_W-1:0] tmr_s_r,  tmr_s_nxt;
  logic [MSEC_W-1:0]   tmr_ms_r, tmr_ms_nxt;
  logic                tmr_on_r, tmr_on_nxt;
  logic                fin_sent_r, fin_sent_nxt;

  logic [SET_H_W-1:0]  ld_h;
  logic [SET_MS_W-1:0] ld_m;
  logic [SET_MS_W-1:0] ld_s;
  logic [7:0]          s_split;
  logic [7:0]          m_sum;
  logic [7:0]          m_split;
  logic [HRS_W-1:0]    norm_h;
  logic                tmr_zero;
  logic                ev_start, ev_stop, ev_fin;

  // Splits a value below 180 into a carry of whole sixties and a remainder.
  function automatic logic [7:0] split60(input logic [7:0] v);
    logic [7:0] rem;
    logic [1:0] carry;
    if (v >= 8'd120) begin
      carry = 2'd2;
      rem   = v - 8'd120;
    end else if (v >= 8'd60) begin
      carry = 2'd1;
      rem   = v - 8'd60;
    end else begin
      carry = 2'd0;
      rem   = v;
    end
    return {carry, rem[5:0]};
  endfunction

  // Clamp hours to 12 (minutes, then seconds, to 59 at 12), then bring loose minutes and seconds into range.
  always_comb begin
    ld_h = (cmd.set_hours > TMR_HOUR_MAX) ? TMR_HOUR_MAX : cmd.set_hours;
    ld_m = cmd.set_minutes;
    ld_s = cmd.set_seconds;
    if (ld_h == TMR_HOUR_MAX && ld_m > SET_FIELD_MAX) begin
      ld_m = SET_FIELD_MAX;
    end
    if (ld_h == TMR_HOUR_MAX && ld_m == SET_FIELD_MAX && ld_s > SET_FIELD_MAX) begin
      ld_s = SET_FIELD_MAX;
    end
    s_split = split60({1'b0, ld_s});
    m_sum   = {1'b0, ld_m} + {6'd0, s_split[7:6]};
    m_split = split60(m_sum);
    norm_h  = ld_h + {2'd0, m_split[7:6]};
  end

  assign tmr_zero = (tmr_h_r == '0) && (tmr_m_r == '0) && (tmr_s_r == '0) &&
                    (tmr_ms_r == '0);

  // Next state of the countdown for the item being applied.
  always_comb begin
    tmr_h_nxt    = tmr_h_r;
    tmr_m_nxt    = tmr_m_r;
    tmr_s_nxt    = tmr_s_r;
    tmr_ms_nxt   = tmr_ms_r;
    tmr_on_nxt   = tmr_on_r;
    fin_sent_nxt = fin_sent_r;
    ev_start     = 1'b0;
    ev_stop      = 1'b0;
    ev_fin       = 1'b0;
    if (cmd.fire) begin
      case (cmd.op)
        OP_TICK: begin
          // Count down with borrow, holding at zero.
          if (tmr_on_r && !tmr_zero) begin
            if (tmr_ms_r != '0) begin
              tmr_ms_nxt = tmr_ms_r - 1'b1;
            end else begin
              tmr_ms_nxt = MS_LAST;
              if (tmr_s_r != '0) begin
                tmr_s_nxt = tmr_s_r - 1'b1;
              end else begin
                tmr_s_nxt = SM_LAST;
                if (tmr_m_r != '0) begin
                  tmr_m_nxt = tmr_m_r - 1'b1;
                end else begin
                  tmr_m_nxt = SM_LAST;
                  tmr_h_nxt = tmr_h_r - 1'b1;
                end
              end
            end
          end
          // Finished once less than one second remains.
          if (tmr_on_r && !fin_sent_r && tmr_h_nxt == '0 && tmr_m_nxt == '0 &&
              tmr_s_nxt == '0) begin
            fin_sent_nxt = 1'b1;
            ev_fin       = 1'b1;
          end
        end
        OP_TMR_START: begin
          tmr_h_nxt    = norm_h;
          tmr_m_nxt    = m_split[5:0];
          tmr_s_nxt    = s_split[5:0];
          tmr_ms_nxt   = '0;
          tmr_on_nxt   = 1'b1;
          fin_sent_nxt = 1'b0;
          ev_start     = 1'b1;
        end
        OP_TMR_STOP: begin
          tmr_on_nxt = 1'b0;
          ev_stop    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_h_r    <= '0;
      tmr_m_r    <= '0;
      tmr_s_r    <= '0;
      tmr_ms_r   <= '0;
      tmr_on_r   <= 1'b0;
      fin_sent_r <= 1'b0;
    end else begin
      tmr_h_r    <= tmr_h_nxt;
      tmr_m_r    <= tmr_m_nxt;
      tmr_s_r    <= tmr_s_nxt;
      tmr_ms_r   <= tmr_ms_nxt;
      tmr_on_r   <= tmr_on_nxt;
      fin_sent_r <= fin_sent_nxt;
    end
  end

  // Status after the item, for the result register.
  always_comb begin
    stat.running     = tmr_on_nxt;
    stat.hours       = tmr_h_nxt;
    stat.minutes     = tmr_m_nxt;
    stat.seconds     = tmr_s_nxt;
    stat.ev_started  = ev_start;
    stat.ev_stopped  = ev_stop;
    stat.ev_finished = ev_fin;
  end

  `CDSAT_ASSERT(a_tmr_digits, tmr_m_r <= SM_LAST && tmr_s_r <= SM_LAST && tmr_ms_r <= MS_LAST, "countdown digit out of range")

endmodule

`default_nettype wire

FILE: design/cdsat_stopwatch.sv
// Stopwatch counting up to 11:59:59.999 with a minute event.
`default_nettype none
`include "countdown_stopwatch_alarm_timer_unit_defines.svh"

module cdsat_stopwatch (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdsat_pkg::cmd_t      cmd,
  output cdsat_pkg::sw_stat_t  stat
);
  import cdsat_pkg::*;

  logic [HRS_W-1:0]    sw_h_r,  sw_h_nxt;
  logic [MINSEC_W-1:0] sw_m_r,  sw_m_nxt;
  logic [MINSEC_W-1:0] sw_s_r,  sw_s_nxt;
  logic [MSEC_W-1:0]   sw_ms_r, sw_ms_nxt;
  logic                sw_on_r, sw_on_nxt;
  logic [MINUTE_W-1:0] last_min_r, last_min_nxt;

  logic at_cap;
  logic ev_start, ev_pause, ev_reset, ev_minute;

  assign at_cap = (sw_h_r == SW_HOUR_LAST) && (sw_m_r == SM_LAST) &&
                  (sw_s_r == SM_LAST) && (sw_ms_r == MS_LAST);

  // Next state of the stopwatch for the item being applied.
  always_comb begin
    sw_h_nxt     = sw_h_r;
    sw_m_nxt     = sw_m_r;
    sw_s_nxt     = sw_s_r;
    sw_ms_nxt    = sw_ms_r;
    sw_on_nxt    = sw_on_r;
    last_min_nxt = last_min_r;
    ev_start     = 1'b0;
    ev_pause     = 1'b0;
    ev_reset     = 1'b0;
    ev_minute    = 1'b0;
    if (cmd.fire) begin
      case (cmd.op)
        OP_TICK: begin
          // Count up with carry, holding at the cap.
          if (sw_on_r && !at_cap) begin
            if (sw_ms_r != MS_LAST) begin
              sw_ms_nxt = sw_ms_r + 1'b1;
            end else begin
              sw_ms_nxt = '0;
              if (sw_s_r != SM_LAST) begin
                sw_s_nxt = sw_s_r + 1'b1;
              end else begin
                sw_s_nxt = '0;
                if (sw_m_r != SM_LAST) begin
                  sw_m_nxt = sw_m_r + 1'b1;
                end else begin
                  sw_m_nxt = '0;
                  sw_h_nxt = sw_h_r + 1'b1;
                end
              end
            end
          end
          // A change of minute raises the event unless none was seen yet.
          if (sw_on_r && {1'b0, sw_m_nxt} != last_min_r) begin
            ev_minute    = (last_min_r != NO_MINUTE);
            last_min_nxt = {1'b0, sw_m_nxt};
          end
        end
        OP_SW_START: begin
          if (!sw_on_r) begin
            sw_on_nxt    = 1'b1;
            last_min_nxt = NO_MINUTE;
            ev_start     = 1'b1;
          end
        end
        OP_SW_PAUSE: begin
          if (sw_on_r) begin
            sw_on_nxt = 1'b0;
            ev_pause  = 1'b1;
          end
        end
        OP_SW_RESET: begin
          sw_h_nxt     = '0;
          sw_m_nxt     = '0;
          sw_s_nxt     = '0;
          sw_ms_nxt    = '0;
          last_min_nxt = NO_MINUTE;
          ev_reset     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_h_r     <= '0;
      sw_m_r     <= '0;
      sw_s_r     <= '0;
      sw_ms_r    <= '0;
      sw_on_r    <= 1'b0;
      last_min_r <= NO_MINUTE;
    end else begin
      sw_h_r     <= sw_h_nxt;
      sw_m_r     <= sw_m_nxt;
      sw_s_r     <= sw_s_nxt;
      sw_ms_r    <= sw_ms_nxt;
      sw_on_r    <= sw_on_nxt;
      last_min_r <= last_min_nxt;
    end
  end

  // Status after the item, for the result register.
  always_comb begin
    stat.running    = sw_on_nxt;
    stat.hours      = sw_h_nxt;
    stat.minutes    = sw_m_nxt;
    stat.seconds    = sw_s_nxt;
    stat.ev_started = ev_start;
    stat.ev_paused  = ev_pause;
    stat.ev_reset   = ev_reset;
    stat.ev_minute  = ev_minute;
  end

  `CDSAT_ASSERT(a_sw_cap, sw_h_r <= SW_HOUR_LAST && sw_m_r <= SM_LAST && sw_s_r <= SM_LAST && sw_ms_r <= MS_LAST, "stopwatch beyond its cap")

endmodule

`default_nettype wire

FILE: design/cdsat_alarm.sv
// Alarm with an age counter that dismisses it after the hold time.
`default_nettype none
`include "countdown_stopwatch_alarm_timer_unit_defines.svh"

module cdsat_alarm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cdsat_pkg::cmd_t                 cmd,
  input  logic [cdsat_pkg::HOLD_W-1:0]    hold_ms,
  output cdsat_pkg::alm_stat_t            stat
);
  import cdsat_pkg::*;

  logic [AGE_W-1:0] alm_age_r, alm_age_nxt;
  logic             alm_on_r,  alm_on_nxt;
  logic             ev_alarm;

  // Next state of the alarm for the item being applied.
  always_comb begin
    alm_age_nxt = alm_age_r;
    alm_on_nxt  = alm_on_r;
    ev_alarm    = 1'b0;
    if (cmd.fire) begin
      case (cmd.op)
        OP_TICK: begin
          if (alm_on_r && alm_age_r != AGE_MAX) begin
            alm_age_nxt = alm_age_r + 1'b1;
          end
          if (alm_on_r && alm_age_nxt > {1'b0, hold_ms}) begin
            alm_on_nxt = 1'b0;
          end
        end
        OP_ALARM_START: begin
          alm_age_nxt = '0;
          alm_on_nxt  = 1'b1;
          ev_alarm    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alm_age_r <= '0;
      alm_on_r  <= 1'b0;
    end else begin
      alm_age_r <= alm_age_nxt;
      alm_on_r  <= alm_on_nxt;
    end
  end

  always_comb begin
    stat.showing  = alm_on_nxt;
    stat.ev_alarm = ev_alarm;
  end

  `CDSAT_ASSERT_NEXT(a_alm_start, cmd.fire && cmd.op == OP_ALARM_START, alm_on_r, "alarm not showing after start")

endmodule

`default_nettype wire

FILE: design/countdown_stopwatch_alarm_timer_unit.sv
// Top level: input register, timer units, configuration and result register.
// An accepted item waits in the input register until the result register is
// free, then its result is loaded there and offered. Throughput: one item per
// cycle while results are taken; while a result waits, one more item is held.
// Reset (rst_n low, synchronous) clears all counters and flags, turns sound on,
// sets the alarm hold to 10000 ms and leaves both channels empty.
`default_nettype none

module countdown_stopwatch_alarm_timer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  cdsat_in_if.sink                          in_ch,
  cdsat_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [cdsat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdsat_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import cdsat_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]     s1_op_r;
  logic [SET_H_W-1:0]  s1_h_r;
  logic [SET_MS_W-1:0] s1_m_r;
  logic [SET_MS_W-1:0] s1_s_r;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;
  logic                sound_en_r, sound_en_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;

  logic      in_take;
  logic      fire;
  cmd_t      cmd;
  tmr_stat_t tmr_stat;
  sw_stat_t  sw_stat;
  alm_stat_t alm_stat;
  logic [EV_W-2:0] ev_sound;

  // Handshake: the held item is applied when the result register is free.
  assign fire         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || fire;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_comb begin
    cmd.fire        = fire;
    cmd.op          = op_t'(s1_op_r);
    cmd.set_hours   = s1_h_r;
    cmd.set_minutes = s1_m_r;
    cmd.set_seconds = s1_s_r;
  end

  cdsat_countdown u_countdown (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (tmr_stat)
  );

  cdsat_stopwatch u_stopwatch (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (sw_stat)
  );

  cdsat_alarm u_alarm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .hold_ms (hold_r),
    .stat    (alm_stat)
  );

  // Configuration writes.
  always_comb begin
    sound_en_nxt = sound_en_r;
    hold_nxt     = hold_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SOUND_ENABLE: sound_en_nxt = cfg_data[0];
        CFG_ALARM_HOLD:   hold_nxt     = cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Assemble the result; timer and stopwatch events drop while sound is off.
  always_comb begin
    ev_sound = '0;
    ev_sound[EV_TMR_START] = tmr_stat.ev_started;
    ev_sound[EV_TMR_STOP]  = tmr_stat.ev_stopped;
    ev_sound[EV_TMR_FIN]   = tmr_stat.ev_finished;
    ev_sound[EV_SW_START]  = sw_stat.ev_started;
    ev_sound[EV_SW_PAUSE]  = sw_stat.ev_paused;
    ev_sound[EV_SW_RESET]  = sw_stat.ev_reset;
    ev_sound[EV_SW_MINUTE] = sw_stat.ev_minute;
    out_res_nxt = out_res_r;
    if (fire) begin
      out_res_nxt.event_mask        = {alm_stat.ev_alarm,
                                       ev_sound & {(EV_W-1){sound_en_r}}};
      out_res_nxt.timer_running     = tmr_stat.running;
      out_res_nxt.timer_hours       = tmr_stat.hours;
      out_res_nxt.timer_minutes     = tmr_stat.minutes;
      out_res_nxt.timer_seconds     = tmr_stat.seconds;
      out_res_nxt.stopwatch_running = sw_stat.running;
      out_res_nxt.stopwatch_hours   = sw_stat.hours;
      out_res_nxt.stopwatch_minutes = sw_stat.minutes;
      out_res_nxt.stopwatch_seconds = sw_stat.seconds;
      out_res_nxt.alarm_showing     = alm_stat.showing;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sound_en_r  <= 1'b1;
      hold_r      <= HOLD_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sound_en_r  <= sound_en_nxt;
      hold_r      <= hold_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_ch.operation;
      s1_h_r  <= in_ch.set_hours;
      s1_m_r  <= in_ch.set_minutes;
      s1_s_r  <= in_ch.set_seconds;
    end
    out_res_r <= out_res_nxt;
  end

  // Result channel.
  assign out_ch.valid             = out_valid_r;
  assign out_ch.event_mask        = out_res_r.event_mask;
  assign out_ch.timer_running     = out_res_r.timer_running;
  assign out_ch.timer_hours       = out_res_r.timer_hours;
  assign out_ch.timer_minutes     = out_res_r.timer_minutes;
  assign out_ch.timer_seconds     = out_res_r.timer_seconds;
  assign out_ch.stopwatch_running = out_res_r.stopwatch_running;
  assign out_ch.stopwatch_hours   = out_res_r.stopwatch_hours;
  assign out_ch.stopwatch_minutes = out_res_r.stopwatch_minutes;
  assign out_ch.stopwatch_seconds = out_res_r.stopwatch_seconds;
  assign out_ch.alarm_showing     = out_res_r.alarm_showing;

endmodule

`default_nettype wire
